### hw/rtl/avg_pkg.sv
`default_nettype none
package avg_pkg;

	localparam int unsigned VERTEX_COUNT = 9;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam logic [3:0] LAST_INDEX = 4'(VERTEX_COUNT - 1);

	typedef enum logic [1:0] {
		REG_HEAD_LENGTH   = 2'd0,
		REG_HEAD_WIDTH    = 2'd1,
		REG_SHAFT_SHORTEN = 2'd2,
		REG_MIN_LENGTH_SQ = 2'd3
	} reg_index_t;

	typedef struct packed {
		logic signed [23:0] start_x;
		logic signed [23:0] start_y;
		logic signed [23:0] end_x;
		logic signed [23:0] end_y;
		logic [15:0]        thickness;
	} segment_t;

	typedef struct packed {
		logic [3:0]         vertex_index;
		logic signed [23:0] vertex_x;
		logic signed [23:0] vertex_y;
		logic               last_vertex;
	} vertex_t;

	typedef struct packed {
		logic [11:0] head_length_ratio;
		logic [11:0] head_width_ratio;
		logic [8:0]  shaft_shorten_ratio;
		logic [15:0] min_length_squared;
	} cfg_t;

	// line as queued between classifier and engine
	typedef struct packed {
		segment_t    seg;
		logic [23:0] adx;
		logic [23:0] ady;
		logic        neg_x;
		logic        neg_y;
		logic [48:0] l2;
	} job_t;

	localparam cfg_t CFG_RESET = '{
		head_length_ratio:   12'd1536,
		head_width_ratio:    12'd896,
		shaft_shorten_ratio: 9'd179,
		min_length_squared:  16'd1
	};

	function automatic logic signed [23:0] sat_coord(input logic signed [27:0] v);
		logic signed [23:0] r;
		if (v > 28'sh07FFFFF) begin
			r = 24'sh7FFFFF;
		end else if (v < -28'sh0800000) begin
			r = -24'sh800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

endpackage
`default_nettype wire

### hw/rtl/avg_front.sv
`default_nettype none
module avg_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             accept,
	input  wire avg_pkg::segment_t seg,
	input  wire logic [15:0]      min_length_squared,
	output logic                  push,
	output avg_pkg::job_t         job,
	output logic [1:0]            pending
);

	logic              v_s1, v_s2;
	avg_pkg::segment_t seg_s1, seg_s2;
	logic [23:0]       adx_s1, ady_s1, adx_s2, ady_s2;
	logic              negx_s1, negy_s1, negx_s2, negy_s2;
	logic [47:0]       sqx_s2, sqy_s2;
	logic [24:0]       dx, dy, ndx, ndy;
	logic [48:0]       l2;

	assign dx  = {seg.end_x[23], seg.end_x} - {seg.start_x[23], seg.start_x};
	assign dy  = {seg.end_y[23], seg.end_y} - {seg.start_y[23], seg.start_y};
	assign ndx = -dx;
	assign ndy = -dy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			seg_s1  <= seg;
			negx_s1 <= dx[24];
			negy_s1 <= dy[24];
			adx_s1  <= dx[24] ? ndx[23:0] : dx[23:0];
			ady_s1  <= dy[24] ? ndy[23:0] : dy[23:0];
		end
		if (v_s1) begin
			seg_s2  <= seg_s1;
			negx_s2 <= negx_s1;
			negy_s2 <= negy_s1;
			adx_s2  <= adx_s1;
			ady_s2  <= ady_s1;
			sqx_s2  <= adx_s1 * adx_s1;
			sqy_s2  <= ady_s1 * ady_s1;
		end
	end

	// drop zero-length and short lines here
	assign l2   = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign push = v_s2 && (l2 != 49'd0) && (l2 >= {33'd0, min_length_squared});

	assign job = '{seg: seg_s2, adx: adx_s2, ady: ady_s2, neg_x: negx_s2,
		neg_y: negy_s2, l2: l2};

	assign pending = 2'({1'b0, v_s1} + {1'b0, v_s2});

endmodule
`default_nettype wire

### hw/rtl/avg_queue.sv
`default_nettype none
module avg_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire avg_pkg::job_t din,
	input  wire logic          pop,
	output avg_pkg::job_t      dout,
	output logic               empty,
	output logic [$clog2(avg_pkg::QUEUE_DEPTH + 1)-1:0] count
);

	localparam int PTR_W = $clog2(avg_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(avg_pkg::QUEUE_DEPTH + 1);

	avg_pkg::job_t    slot_q [avg_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= din;
		end
	end

	assign dout  = slot_q[rd_ptr_q];
	assign empty = (count_q == '0);
	assign count = count_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(avg_pkg::QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q != CNT_W'(avg_pkg::QUEUE_DEPTH))
		else $error("push into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
`endif

endmodule
`default_nettype wire

### hw/rtl/avg_back.sv
`default_nettype none
module avg_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire avg_pkg::cfg_t cfg,
	input  wire logic          job_valid,
	input  wire avg_pkg::job_t job,
	output logic               pop,
	output avg_pkg::vertex_t   vertex,
	output logic               strobe
);

	typedef enum logic [3:0] {
		IDLE, SQRT, DIV_SETUP, DIV, MUL1, MUL2, MUL3, MUL4, EMIT
	} state_t;

	state_t           state_q;
	logic [4:0]       cnt_q;
	logic [3:0]       idx_q;
	avg_pkg::vertex_t vertex_q;
	logic             strobe_q;

	avg_pkg::job_t job_q;
	logic [49:0]   rad_q;
	logic [27:0]   rem_q;
	logic [24:0]   root_q;
	logic [24:0]   rx_q, ry_q;
	logic [16:0]   nx_q, ny_q, qx_q, qy_q;
	logic [32:0]   mtx_q, mty_q;
	logic [44:0]   hwx_q, hwy_q, hlx_q, hly_q;
	logic [53:0]   sbx_q, sby_q;
	logic [15:0]   pmx_q, pmy_q;
	logic [19:0]   hmx_q, hmy_q;
	logic [20:0]   bmx_q, bmy_q;
	logic signed [27:0] sx_q, sy_q, ex_q, ey_q, lx_q, ly_q, bx_q, by_q;
	logic signed [27:0] px_q, py_q, hx_q, hy_q;

	logic [29:0] rem_sh, trial, rem_sub;
	logic        sq_ge;
	logic [40:0] numx, numy;
	logic [25:0] rx_sh, ry_sh;
	logic        gex, gey;
	logic [32:0] mtx_r, mty_r;
	logic [44:0] hwx_r, hwy_r, hlx_r, hly_r;
	logic [53:0] sbx_r, sby_r;
	logic [21:0] cmx, cmy;
	logic signed [27:0] ex_w, ey_w, sx_w, sy_w;
	logic signed [27:0] base_x, base_y, off_x, off_y, vx, vy;
	logic               sub_off;

	// one root bit per step
	assign rem_sh  = {rem_q, rad_q[49:48]};
	assign trial   = {3'd0, root_q, 2'b01};
	assign sq_ge   = rem_sh >= trial;
	assign rem_sub = rem_sh - trial;

	assign numx = {1'b0, job_q.adx, 16'd0} + {17'd0, root_q[24:1]};
	assign numy = {1'b0, job_q.ady, 16'd0} + {17'd0, root_q[24:1]};

	// one quotient bit per step, x and y side by side
	assign rx_sh = {rx_q, nx_q[16]};
	assign ry_sh = {ry_q, ny_q[16]};
	assign gex   = rx_sh >= {1'b0, root_q};
	assign gey   = ry_sh >= {1'b0, root_q};

	// round half up on magnitudes
	assign mtx_r = mtx_q + 33'h0_0001_0000;
	assign mty_r = mty_q + 33'h0_0001_0000;
	assign hwx_r = hwx_q + 45'h0_0100_0000;
	assign hwy_r = hwy_q + 45'h0_0100_0000;
	assign hlx_r = hlx_q + 45'h0_0080_0000;
	assign hly_r = hly_q + 45'h0_0080_0000;
	assign sbx_r = sbx_q + 54'h0_0000_8000_0000;
	assign sby_r = sby_q + 54'h0_0000_8000_0000;
	assign cmx   = sbx_r[53:32];
	assign cmy   = sby_r[53:32];

	assign sx_w = $signed({{4{job_q.seg.start_x[23]}}, job_q.seg.start_x});
	assign sy_w = $signed({{4{job_q.seg.start_y[23]}}, job_q.seg.start_y});
	assign ex_w = $signed({{4{job_q.seg.end_x[23]}}, job_q.seg.end_x});
	assign ey_w = $signed({{4{job_q.seg.end_y[23]}}, job_q.seg.end_y});

	always_comb begin
		base_x  = sx_q;
		base_y  = sy_q;
		off_x   = px_q;
		off_y   = py_q;
		sub_off = 1'b0;
		case (idx_q)
			4'd0: begin
				sub_off = 1'b0;
			end
			4'd1, 4'd3: begin
				sub_off = 1'b1;
			end
			4'd2, 4'd5: begin
				base_x = lx_q;
				base_y = ly_q;
			end
			4'd4: begin
				base_x  = lx_q;
				base_y  = ly_q;
				sub_off = 1'b1;
			end
			4'd6: begin
				base_x = ex_q;
				base_y = ey_q;
				off_x  = '0;
				off_y  = '0;
			end
			4'd7: begin
				base_x = bx_q;
				base_y = by_q;
				off_x  = hx_q;
				off_y  = hy_q;
			end
			4'd8: begin
				base_x  = bx_q;
				base_y  = by_q;
				off_x   = hx_q;
				off_y   = hy_q;
				sub_off = 1'b1;
			end
			default: begin
				sub_off = 1'b0;
			end
		endcase
		vx = sub_off ? base_x - off_x : base_x + off_x;
		vy = sub_off ? base_y - off_y : base_y + off_y;
	end

	assign pop = (state_q == IDLE) && job_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			strobe_q <= 1'b0;
			vertex_q <= '0;
		end else begin
			strobe_q <= 1'b0;
			case (state_q)
				IDLE: begin
					cnt_q <= '0;
					if (job_valid) begin
						state_q <= SQRT;
					end
				end
				SQRT: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd24) begin
						state_q <= DIV_SETUP;
					end
				end
				DIV_SETUP: begin
					cnt_q   <= '0;
					state_q <= DIV;
				end
				DIV: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= MUL1;
					end
				end
				MUL1: state_q <= MUL2;
				MUL2: state_q <= MUL3;
				MUL3: state_q <= MUL4;
				MUL4: begin
					idx_q   <= '0;
					state_q <= EMIT;
				end
				EMIT: begin
					strobe_q <= 1'b1;
					vertex_q <= '{vertex_index: idx_q,
						vertex_x: avg_pkg::sat_coord(vx),
						vertex_y: avg_pkg::sat_coord(vy),
						last_vertex: idx_q == avg_pkg::LAST_INDEX};
					idx_q <= idx_q + 4'd1;
					if (idx_q == avg_pkg::LAST_INDEX) begin
						state_q <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			IDLE: begin
				job_q  <= job;
				rad_q  <= {1'b0, job.l2};
				rem_q  <= '0;
				root_q <= '0;
			end
			SQRT: begin
				rem_q  <= sq_ge ? rem_sub[27:0] : rem_sh[27:0];
				root_q <= {root_q[23:0], sq_ge};
				rad_q  <= {rad_q[47:0], 2'b00};
			end
			DIV_SETUP: begin
				rx_q <= {1'b0, numx[40:17]};
				ry_q <= {1'b0, numy[40:17]};
				nx_q <= numx[16:0];
				ny_q <= numy[16:0];
				qx_q <= '0;
				qy_q <= '0;
			end
			DIV: begin
				rx_q <= gex ? 25'(rx_sh - {1'b0, root_q}) : rx_sh[24:0];
				ry_q <= gey ? 25'(ry_sh - {1'b0, root_q}) : ry_sh[24:0];
				nx_q <= {nx_q[15:0], 1'b0};
				ny_q <= {ny_q[15:0], 1'b0};
				qx_q <= {qx_q[15:0], gex};
				qy_q <= {qy_q[15:0], gey};
			end
			MUL1: begin
				mtx_q <= {16'd0, qx_q} * {17'd0, job_q.seg.thickness};
				mty_q <= {16'd0, qy_q} * {17'd0, job_q.seg.thickness};
			end
			MUL2: begin
				hwx_q <= {12'd0, mtx_q} * {33'd0, cfg.head_width_ratio};
				hwy_q <= {12'd0, mty_q} * {33'd0, cfg.head_width_ratio};
				hlx_q <= {12'd0, mtx_q} * {33'd0, cfg.head_length_ratio};
				hly_q <= {12'd0, mty_q} * {33'd0, cfg.head_length_ratio};
				pmx_q <= mtx_r[32:17];
				pmy_q <= mty_r[32:17];
			end
			MUL3: begin
				sbx_q <= {9'd0, hlx_q} * {45'd0, cfg.shaft_shorten_ratio};
				sby_q <= {9'd0, hly_q} * {45'd0, cfg.shaft_shorten_ratio};
				hmx_q <= hwx_r[44:25];
				hmy_q <= hwy_r[44:25];
				bmx_q <= hlx_r[44:24];
				bmy_q <= hly_r[44:24];
			end
			MUL4: begin
				// perpendicular is (-uy, ux); apply component signs
				sx_q <= sx_w;
				sy_q <= sy_w;
				ex_q <= ex_w;
				ey_q <= ey_w;
				px_q <= job_q.neg_y ? $signed({12'd0, pmy_q}) : -$signed({12'd0, pmy_q});
				py_q <= job_q.neg_x ? -$signed({12'd0, pmx_q}) : $signed({12'd0, pmx_q});
				hx_q <= job_q.neg_y ? $signed({8'd0, hmy_q}) : -$signed({8'd0, hmy_q});
				hy_q <= job_q.neg_x ? -$signed({8'd0, hmx_q}) : $signed({8'd0, hmx_q});
				lx_q <= job_q.neg_x ? ex_w + $signed({6'd0, cmx}) : ex_w - $signed({6'd0, cmx});
				ly_q <= job_q.neg_y ? ey_w + $signed({6'd0, cmy}) : ey_w - $signed({6'd0, cmy});
				bx_q <= job_q.neg_x ? ex_w + $signed({7'd0, bmx_q})
					: ex_w - $signed({7'd0, bmx_q});
				by_q <= job_q.neg_y ? ey_w + $signed({7'd0, bmy_q})
					: ey_w - $signed({7'd0, bmy_q});
			end
			default: begin
				rad_q <= rad_q;
			end
		endcase
	end

	assign vertex = vertex_q;
	assign strobe = strobe_q;

endmodule
`default_nettype wire

### hw/rtl/arrow_vertex_generator_core.sv
`default_nettype none
// Channel   Handshake            Payload
// -------   ------------------   ----------------------------------------
// line in   start / busy         segment: start, end, thickness
// vertex    vertex_strobe only   vertex: index, x, y, last mark
// config    cfg_we               cfg_index selects register, cfg_data
//
// A drawable line passes through the engine in order: a load, the square root,
// one setup, both divisions side by side, four multiply steps and nine vertex
// transfers, one line at a time; the bit-serial root and divide loops set the rate.
// Two classifier stages feed a four-deep queue; busy holds once lines in flight
// fill it. Short lines are dropped at the second classifier stage.
// The vertex receiver cannot stall. Reset restores register defaults and empties all.
module arrow_vertex_generator_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire avg_pkg::segment_t segment,
	input  wire logic              cfg_we,
	input  wire logic [1:0]        cfg_index,
	input  wire logic [15:0]       cfg_data,
	output avg_pkg::vertex_t       vertex,
	output logic                   vertex_strobe
);

	localparam int CNT_W = $clog2(avg_pkg::QUEUE_DEPTH + 1);

	avg_pkg::cfg_t    cfg_q;
	avg_pkg::job_t    fr_job, q_job;
	logic             fr_push, q_pop, q_empty, accept;
	logic [1:0]       fr_pending;
	logic [CNT_W-1:0] q_count;

	// hold off new lines once everything in flight would fill the queue
	assign busy   = ({2'd0, q_count} + {{CNT_W{1'b0}}, fr_pending})
		>= (CNT_W + 2)'(avg_pkg::QUEUE_DEPTH);
	assign accept = start && !busy;

	// register writes; each two-bit index selects one of the four registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= avg_pkg::CFG_RESET;
		end else if (cfg_we) begin
			case (avg_pkg::reg_index_t'(cfg_index))
				avg_pkg::REG_HEAD_LENGTH:   cfg_q.head_length_ratio   <= cfg_data[11:0];
				avg_pkg::REG_HEAD_WIDTH:    cfg_q.head_width_ratio    <= cfg_data[11:0];
				avg_pkg::REG_SHAFT_SHORTEN: cfg_q.shaft_shorten_ratio <= cfg_data[8:0];
				avg_pkg::REG_MIN_LENGTH_SQ: cfg_q.min_length_squared  <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	avg_front u_front (
		.clk                (clk),
		.arst_n             (arst_n),
		.accept             (accept),
		.seg                (segment),
		.min_length_squared (cfg_q.min_length_squared),
		.push               (fr_push),
		.job                (fr_job),
		.pending            (fr_pending)
	);

	avg_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (fr_push),
		.din    (fr_job),
		.pop    (q_pop),
		.dout   (q_job),
		.empty  (q_empty),
		.count  (q_count)
	);

	avg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.job_valid (!q_empty),
		.job       (q_job),
		.pop       (q_pop),
		.vertex    (vertex),
		.strobe    (vertex_strobe)
	);

`ifndef SYNTHESIS
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_strobe && vertex.last_vertex |-> vertex.vertex_index == avg_pkg::LAST_INDEX)
		else $error("last mark on wrong vertex");
	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_strobe && vertex.vertex_index != 4'd0 |->
		$past(vertex_strobe) && $past(vertex.vertex_index) == vertex.vertex_index - 4'd1)
		else $error("vertex run broken");
	a_run_start: assert property (@(posedge clk) disable iff (!arst_n)
		vertex_strobe && vertex.vertex_index == 4'd0 |-> !$past(vertex_strobe))
		else $error("run starts without gap");
`endif

endmodule
`default_nettype wire
